### hw/rtl/wsdu_pkg.sv
package wsdu_pkg;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_MASK   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } phase_t;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned MASK_BYTES = 4;
  localparam int unsigned KEY_W      = BYTE_W * MASK_BYTES;
  localparam int unsigned IDX_W      = $clog2(MASK_BYTES);

  localparam int unsigned MASK_BIT_POS = 7;
  localparam logic [6:0]  LEN_EXT16    = 7'd126;
  localparam logic [6:0]  LEN_EXT64    = 7'd127;
  localparam logic [IDX_W-1:0] HC_LAST_MASK = IDX_W'(MASK_BYTES - 1);
  localparam logic [IDX_W-1:0] HC_LAST_EXT  = IDX_W'(1);

  typedef struct packed {
    phase_t                 phase;
    logic [LEN_W-1:0]       remaining_len;
    logic [KEY_W-1:0]       mask_key;
    logic [IDX_W-1:0]       mask_index;
    logic [IDX_W-1:0]       header_count;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_in_frame;
    logic              frame_error;
  } parse_result_t;

endpackage

### hw/rtl/wsdu_if.sv
interface wsdu_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface wsdu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_in_frame;
  logic       frame_error;

  modport source (output valid, output payload_byte, output last_in_frame,
                  output frame_error, input ready);
  modport sink   (input valid, input payload_byte, input last_in_frame,
                  input frame_error, output ready);
endinterface

### hw/rtl/wsdu_parse.sv
module wsdu_parse
  import wsdu_pkg::*;
(
  input  parse_state_t      st,
  input  logic              action,
  input  logic [BYTE_W-1:0] rx_byte,
  output parse_state_t      st_nxt,
  output parse_result_t     res
);

  logic [6:0]        len;
  logic [BYTE_W-1:0] key_byte;
  logic [LEN_W-1:0]  rem_dec;

  assign len      = rx_byte[6:0];
  assign key_byte = st.mask_key[{st.mask_index, 3'b000} +: BYTE_W];
  assign rem_dec  = st.remaining_len - LEN_W'(1);

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (action) begin
      st_nxt       = '0;
      st_nxt.phase = PH_HDR0;
    end else begin
      case (st.phase)
        PH_HDR0: begin
          st_nxt.phase = PH_HDR1;
        end
        PH_HDR1: begin
          if (len == LEN_EXT64 || !rx_byte[MASK_BIT_POS]) begin
            st_nxt.phase    = PH_CLOSED;
            res.valid       = 1'b1;
            res.frame_error = 1'b1;
          end else begin
            st_nxt.header_count = '0;
            st_nxt.mask_key     = '0;
            if (len == LEN_EXT16) begin
              st_nxt.remaining_len = '0;
              st_nxt.phase         = PH_EXTLEN;
            end else begin
              st_nxt.remaining_len = LEN_W'(len);
              st_nxt.phase         = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          st_nxt.remaining_len = {st.remaining_len[LEN_W-BYTE_W-1:0], rx_byte};
          if (st.header_count == HC_LAST_EXT) begin
            st_nxt.header_count = '0;
            st_nxt.phase        = PH_MASK;
          end else begin
            st_nxt.header_count = HC_LAST_EXT;
          end
        end
        PH_MASK: begin
          st_nxt.mask_key[{st.header_count, 3'b000} +: BYTE_W] =
            st.mask_key[{st.header_count, 3'b000} +: BYTE_W] | rx_byte;
          if (st.header_count == HC_LAST_MASK) begin
            st_nxt.header_count = '0;
            st_nxt.mask_index   = '0;
            st_nxt.phase        = (st.remaining_len == '0) ? PH_HDR0 : PH_DATA;
          end else begin
            st_nxt.header_count = st.header_count + IDX_W'(1);
          end
        end
        PH_DATA: begin
          st_nxt.mask_index    = st.mask_index + IDX_W'(1);
          st_nxt.remaining_len = rem_dec;
          res.valid            = 1'b1;
          res.payload_byte     = rx_byte ^ key_byte;
          res.last_in_frame    = (rem_dec == '0);
          if (rem_dec == '0) begin
            st_nxt.phase = PH_HDR0;
          end
        end
        default: begin
          // link closed: wait for restart
        end
      endcase
    end
  end

endmodule

### hw/rtl/websocket_frame_deframer_unmask_core.sv
// Receive-side WebSocket deframer: takes one link byte per item (or a restart
// item), skips the frame header, length and mask bytes, and returns each
// payload byte unmasked with the frame's final byte flagged. A frame with a
// 64-bit length or a clear mask bit gives one error item, after which data
// items are dropped until a restart. The block takes one item every cycle
// while the output is not stalled; an item passes an input register, a
// combinational parse/unmask step, and an output register, from which the
// result is presented until it is accepted.
// Header bytes, zero-length frames and dropped bytes produce no result.
module websocket_frame_deframer_unmask_core
  import wsdu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wsdu_in_if.sink    in_ch,
  wsdu_out_if.source out_ch
);

  logic              in_vld_r;
  logic              action_r;
  logic [BYTE_W-1:0] byte_r;

  parse_state_t      st_r;
  parse_state_t      st_nxt;
  parse_result_t     res;

  logic              out_vld_r;
  logic [BYTE_W-1:0] pay_r;
  logic              last_r;
  logic              err_r;

  logic              out_free;
  logic              fire;
  logic              in_take;

  assign out_free = !out_vld_r || out_ch.ready;
  assign fire     = in_vld_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_vld_r || fire;

  wsdu_parse u_parse (
    .st      (st_r),
    .action  (action_r),
    .rx_byte (byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_ch.action;
      byte_r   <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_HDR0, default: '0};
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      pay_r  <= res.payload_byte;
      last_r <= res.last_in_frame;
      err_r  <= res.frame_error;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_byte  = pay_r;
  assign out_ch.last_in_frame = last_r;
  assign out_ch.frame_error   = err_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && err_r |-> pay_r == '0 && !last_r)
    else $error("error item carries payload data");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && action_r |=> st_r.phase == PH_HDR0 && st_r.remaining_len == '0)
    else $error("restart did not clear parser state");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DATA |-> st_r.remaining_len != '0)
    else $error("data phase with no bytes left");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !fire)
    else $error("item processed while result is stalled");

endmodule

### bench/tb_websocket_frame_deframer_unmask_core.sv
module tb_websocket_frame_deframer_unmask_core;
  import wsdu_pkg::*;

  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  localparam int   NUM_ITEMS   = 800;
  localparam int   CALM_AFTER  = 650;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } frame_out_t;

  class ws_unmask_tracker;
    phase_t                 phase;
    logic [LEN_W-1:0]       remaining_len;
    logic [KEY_W-1:0]       mask_key;
    logic [IDX_W-1:0]       mask_index;
    logic [IDX_W-1:0]       header_count;
    frame_out_t             pending_bytes[$];
    int                     mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase         = PH_HDR0;
      remaining_len = '0;
      mask_key      = '0;
      mask_index    = '0;
      header_count  = '0;
    endfunction

    function void note_input(logic act, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] k;
      if (act == ACT_RESTART) begin
        clear();
        return;
      end
      case (phase)
        PH_HDR0: phase = PH_HDR1;
        PH_HDR1: begin
          if (b[6:0] == LEN_EXT64 || !b[MASK_BIT_POS]) begin
            phase = PH_CLOSED;
            pending_bytes.push_back('{8'h00, 1'b0, 1'b1});
          end else begin
            header_count = '0;
            mask_key     = '0;
            if (b[6:0] == LEN_EXT16) begin
              remaining_len = '0;
              phase         = PH_EXTLEN;
            end else begin
              remaining_len = LEN_W'(b[6:0]);
              phase         = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          remaining_len = {remaining_len[LEN_W-9:0], b};
          if (header_count == HC_LAST_EXT) begin
            header_count = '0;
            phase        = PH_MASK;
          end else begin
            header_count = HC_LAST_EXT;
          end
        end
        PH_MASK: begin
          mask_key = mask_key | (KEY_W'(b) << (8 * header_count));
          if (header_count == HC_LAST_MASK) begin
            header_count = '0;
            mask_index   = '0;
            phase        = (remaining_len == '0) ? PH_HDR0 : PH_DATA;
          end else begin
            header_count = header_count + 1'b1;
          end
        end
        PH_DATA: begin
          k             = mask_key[8*mask_index +: 8];
          mask_index    = mask_index + 1'b1;
          remaining_len = remaining_len - 1'b1;
          pending_bytes.push_back('{b ^ k, remaining_len == '0, 1'b0});
          if (remaining_len == '0) phase = PH_HDR0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [BYTE_W-1:0] d, logic l, logic e);
      frame_out_t got, want;
      got = '{d, l, e};
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output item: data %02h last %0b err %0b", d, l, e);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: expected data %02h last %0b err %0b,",
                   want.data, want.last, want.err,
                   " got data %02h last %0b err %0b", got.data, got.last, got.err);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   items_sent;
  int   cycle_count = 0;
  int   stall_left;
  ws_unmask_tracker tracker;

  wsdu_in_if  in_ch();
  wsdu_out_if out_ch();

  websocket_frame_deframer_unmask_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_result(out_ch.payload_byte, out_ch.last_in_frame, out_ch.frame_error);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_input(act, b);
    items_sent++;
  endtask

  // fill < 0: random first header, mask and payload bytes; otherwise these are set to fill
  task automatic send_frame(input logic [7:0] len_byte, input logic [15:0] ext_len,
                            input int n_data, input int fill);
    logic [7:0] v;
    int i;
    v = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
    send_item(ACT_DATA, v);
    send_item(ACT_DATA, len_byte);
    if (len_byte[6:0] == LEN_EXT16) begin
      send_item(ACT_DATA, ext_len[15:8]);
      send_item(ACT_DATA, ext_len[7:0]);
    end
    for (i = 0; i < MASK_BYTES + n_data; i++) begin
      v = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      send_item(ACT_DATA, v);
    end
  endtask

  task automatic send_random_frame();
    int sel;
    int len;
    sel = $urandom_range(0, 19);
    if (sel == 0) len = 0;
    else if (sel == 1) len = 125;
    else if (sel <= 3) len = $urandom_range(0, 300);
    else if (sel == 4) len = $urandom_range(0, 3);
    else len = $urandom_range(1, 20);
    if (sel >= 2 && sel <= 4)
      send_frame({1'b1, LEN_EXT16}, 16'(len), len, -1);
    else
      send_frame({1'b1, 7'(len)}, '0, len, -1);
  endtask

  task automatic send_error_frame();
    logic [7:0] len_byte;
    int i, n;
    case ($urandom_range(0, 2))
      0: len_byte = {1'b1, LEN_EXT64};
      1: len_byte = {1'b0, LEN_EXT64};
      default: len_byte = {1'b0, 7'($urandom_range(0, 126))};
    endcase
    send_item(ACT_DATA, 8'($urandom_range(0, 255)));
    send_item(ACT_DATA, len_byte);
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) send_item(ACT_DATA, 8'($urandom_range(0, 255)));
    send_item(ACT_RESTART, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int r, i, n;
    tracker     = new();
    idle_on     = 1'b1;
    items_sent  = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_DATA;
    in_ch.rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_RESTART, 8'hff);
    send_frame(8'h81, '0, 1, 'h00);
    send_frame(8'h80, '0, 0, 'hff);
    send_frame({1'b1, LEN_EXT16}, 16'd2, 2, -1);
    send_item(ACT_DATA, 8'hff);
    send_item(ACT_DATA, {1'b1, LEN_EXT64});
    send_item(ACT_DATA, 8'h5a);
    send_item(ACT_RESTART, 8'h00);
    send_item(ACT_DATA, 8'h81);
    send_item(ACT_DATA, 8'h05);
    send_item(ACT_DATA, 8'hff);
    send_item(ACT_RESTART, 8'h00);
    send_item(ACT_DATA, 8'h82);
    send_item(ACT_DATA, {1'b0, LEN_EXT64});
    send_item(ACT_RESTART, 8'h00);

    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= CALM_AFTER) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if (tracker.phase == PH_CLOSED ||
            (tracker.phase != PH_HDR0 && $urandom_range(0, 1) == 0))
          send_item(ACT_RESTART, 8'($urandom_range(0, 255)));
        send_random_frame();
      end else if (r < 82) begin
        send_item(ACT_RESTART, 8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        send_error_frame();
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          send_item(($urandom_range(0, 9) == 0) ? ACT_RESTART : ACT_DATA,
                    8'($urandom_range(0, 255)));
      end
    end
    idle_on = 1'b0;
    in_ch.valid <= 1'b0;

    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_bytes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
